// ===== hdl/sat_pkg.sv =====
// Shared constants, types and helpers of the signer account table builder.
`timescale 1ns / 1ps
`default_nettype none
package sat_pkg;
  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W = 256;
  localparam int ENTRY_W = 5;
  localparam int TOT_W = 6;
  localparam int STATUS_W = 3;
  localparam int IN_TDATA_W = 264;
  localparam int OUT_TDATA_W = 288;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUILT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // Writable signers first, then readonly signers, writable, readonly.
  function automatic logic [1:0] class_of(input logic signer, input logic writable);
    class_of = {~signer, ~writable};
  endfunction
endpackage
`default_nettype wire

// ===== hdl/sat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/signer_account_table_builder.sv =====
// Signer account table builder: keyed account table with signer ordering.
//
// The slave channel takes one command per beat: tuser carries the command
// and tdata the 256-bit key and the signer and writable flags. The master
// channel returns results; tuser carries the status and tlast marks the final
// beat of a command. Add, lookup and clear return one beat; build returns one
// beat per entry in signer order, with the old index and the header totals,
// or one status beat if already built or empty. Keys live in a 32-entry RAM
// with registered read data; add and lookup search it one entry at a time,
// reading each key, then comparing it. Build first counts the totals over all
// entries, then makes four class passes, emitting a beat per entry of the class.
// Commands are taken one at a time, only while the sequencer is idle; a
// finished result may still wait in the output register meanwhile.
// When the receiver stalls, the sequencer holds at its next result until the
// output register frees up. Reset empties the table and drops any pending
// result; key RAM contents are not cleared and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none
module signer_account_table_builder
  import sat_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // key_word0, key_word1, key_word2, key_word3, signer_flag, writable_flag
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // command
  input  wire logic [1:0]             s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // entry_index, prior_index, out_key0..3, order_class, signer_total,
  // readonly_signer_total, readonly_other_total
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // status
  output logic [STATUS_W-1:0]         m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_REPLY = 3'd3;
  localparam logic [2:0] S_CNT   = 3'd4;
  localparam logic [2:0] S_BSEL  = 3'd5;
  localparam logic [2:0] S_BEMIT = 3'd6;

  logic [2:0] state_q, state_d;
  cmd_e cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic sflag_q, sflag_d, wflag_q, wflag_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, idx_q, idx_d, pos_q, pos_d;
  logic built_q, built_d;
  logic [MAX_ENTRIES-1:0] sig_q, sig_d, wr_q, wr_d;
  logic [IDX_W-1:0] rank_q [MAX_ENTRIES];
  logic rank_we;
  logic [1:0] pass_q, pass_d;
  logic [TOT_W-1:0] tsig_q, tsig_d, tros_q, tros_d, troo_q, troo_d;
  logic [STATUS_W-1:0] rst_q, rst_d;
  logic [ENTRY_W-1:0] rix_q, rix_d;

  logic ov_q, ov_d, olast_q, olast_d;
  logic [STATUS_W-1:0] ostat_q, ostat_d;
  logic [ENTRY_W-1:0] oent_q, oent_d, opri_q, opri_d;
  logic [KEY_W-1:0] okey_q, okey_d;
  logic [1:0] ocls_q, ocls_d;
  logic [TOT_W-1:0] osig_q, osig_d, oros_q, oros_d, oroo_q, oroo_d;

  logic ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr, ix;
  logic [KEY_W-1:0] ram_rdata;
  logic out_free;

  sat_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(key_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ix = idx_q[IDX_W-1:0];
  assign out_free = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; key_d = key_q;
    sflag_d = sflag_q; wflag_d = wflag_q;
    cnt_d = cnt_q; idx_d = idx_q; pos_d = pos_q; built_d = built_q;
    sig_d = sig_q; wr_d = wr_q; pass_d = pass_q;
    tsig_d = tsig_q; tros_d = tros_q; troo_d = troo_q;
    rst_d = rst_q; rix_d = rix_q;
    ov_d = ov_q && !m_axis_tready_i;
    olast_d = olast_q; ostat_d = ostat_q; oent_d = oent_q; opri_d = opri_q;
    okey_d = okey_q; ocls_d = ocls_q; osig_d = osig_q; oros_d = oros_q; oroo_d = oroo_q;
    ram_we = 1'b0; ram_re = 1'b0; rank_we = 1'b0;
    ram_waddr = cnt_q[IDX_W-1:0];
    ram_raddr = ix;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d = cmd_e'(s_axis_tuser_i);
          key_d = s_axis_tdata_i[KEY_W-1:0];
          sflag_d = s_axis_tdata_i[KEY_W];
          wflag_d = s_axis_tdata_i[KEY_W+1];
          idx_d = '0;
          rix_d = '0;
          unique case (cmd_e'(s_axis_tuser_i))
            CMD_ADD: begin
              if (built_q) begin
                rst_d = ST_REJECTED; state_d = S_REPLY;
              end else begin
                state_d = S_RD;
              end
            end
            CMD_LOOKUP: state_d = S_RD;
            CMD_CLEAR: begin
              cnt_d = '0; built_d = 1'b0; sig_d = '0; wr_d = '0;
              rst_d = ST_OK; state_d = S_REPLY;
            end
            CMD_BUILD: begin
              if (built_q) begin
                rst_d = ST_BUILT; state_d = S_REPLY;
              end else if (cnt_q == '0) begin
                built_d = 1'b1; rst_d = ST_EMPTY; state_d = S_REPLY;
              end else begin
                tsig_d = '0; tros_d = '0; troo_d = '0; state_d = S_CNT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (idx_q == cnt_q) begin
          state_d = S_REPLY;
          if (cmd_q == CMD_LOOKUP) begin
            rst_d = ST_NOT_FOUND;
          end else if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
            rst_d = ST_REJECTED;
          end else begin
            ram_we = 1'b1;
            sig_d[cnt_q[IDX_W-1:0]] = sflag_q;
            wr_d[cnt_q[IDX_W-1:0]] = wflag_q;
            cnt_d = cnt_q + CNT_W'(1);
            rst_d = ST_OK;
            rix_d = ENTRY_W'(cnt_q);
          end
        end else begin
          ram_re = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (ram_rdata == key_q) begin
          state_d = S_REPLY;
          rst_d = ST_OK;
          if (cmd_q == CMD_ADD) begin
            sig_d[ix] = sig_q[ix] | sflag_q;
            wr_d[ix] = wr_q[ix] | wflag_q;
            rix_d = ENTRY_W'(idx_q);
          end else begin
            rix_d = built_q ? ENTRY_W'(rank_q[ix]) : ENTRY_W'(idx_q);
          end
        end else begin
          idx_d = idx_q + CNT_W'(1);
          state_d = S_RD;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          ov_d = 1'b1; olast_d = 1'b1; ostat_d = rst_q; oent_d = rix_q;
          opri_d = '0; okey_d = '0; ocls_d = '0;
          osig_d = '0; oros_d = '0; oroo_d = '0;
          state_d = S_IDLE;
        end
      end
      S_CNT: begin
        if (idx_q == cnt_q) begin
          idx_d = '0; pos_d = '0; pass_d = '0; state_d = S_BSEL;
        end else begin
          tsig_d = tsig_q + TOT_W'(sig_q[ix]);
          tros_d = tros_q + TOT_W'(sig_q[ix] & !wr_q[ix]);
          troo_d = troo_q + TOT_W'(!sig_q[ix] & !wr_q[ix]);
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_BSEL: begin
        if (idx_q == cnt_q) begin
          idx_d = '0;
          if (pass_q == 2'd3) begin
            built_d = 1'b1; state_d = S_IDLE;
          end else begin
            pass_d = pass_q + 2'd1;
          end
        end else if (class_of(sig_q[ix], wr_q[ix]) == pass_q) begin
          ram_re = 1'b1; rank_we = 1'b1; state_d = S_BEMIT;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_BEMIT: begin
        if (out_free) begin
          ov_d = 1'b1; ostat_d = ST_OK;
          oent_d = ENTRY_W'(pos_q); opri_d = ENTRY_W'(idx_q);
          okey_d = ram_rdata; ocls_d = pass_q;
          olast_d = (pos_q + CNT_W'(1) == cnt_q);
          osig_d = tsig_q; oros_d = tros_q; oroo_d = troo_q;
          pos_d = pos_q + CNT_W'(1);
          idx_d = idx_q + CNT_W'(1);
          state_d = S_BSEL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      built_q <= 1'b0;
      sig_q <= '0;
      wr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      built_q <= built_d;
      sig_q <= sig_d;
      wr_q <= wr_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; key_q <= key_d; sflag_q <= sflag_d; wflag_q <= wflag_d;
    idx_q <= idx_d; pos_q <= pos_d; pass_q <= pass_d;
    tsig_q <= tsig_d; tros_q <= tros_d; troo_q <= troo_d;
    rst_q <= rst_d; rix_q <= rix_d;
    olast_q <= olast_d; ostat_q <= ostat_d; oent_q <= oent_d; opri_q <= opri_d;
    okey_q <= okey_d; ocls_q <= ocls_d;
    osig_q <= osig_d; oros_q <= oros_d; oroo_q <= oroo_d;
    if (rank_we) begin
      rank_q[ix] <= pos_q[IDX_W-1:0];
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o = ostat_q;
  assign m_axis_tlast_o = olast_q;
  assign m_axis_tdata_o = {2'b00, oroo_q, oros_q, osig_q, ocls_q, okey_q, opri_q, oent_q};
endmodule
`default_nettype wire

// ===== hdl/sat_checker.sv =====
// Port-level checks of the signer account table builder and their binding.
`timescale 1ns / 1ps
`default_nettype none
module sat_checker
  import sat_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [STATUS_W-1:0]    m_axis_tuser_o,
  input wire logic                   m_axis_tlast_o
);
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("Result beat dropped while stalled.");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("Result beat changed while stalled.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= ST_EMPTY)
    else $error("Status code out of range.");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_OK |->
      m_axis_tlast_o && m_axis_tdata_o[ENTRY_W-1:0] == '0)
    else $error("Error result is not a single beat with index zero.");
endmodule

bind signer_account_table_builder sat_checker u_sat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the signer account table builder stream interface.
`timescale 1ns / 1ps
module tb_top;
  import sat_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [4:0]          idx;
    logic [4:0]          prior;
    logic [255:0]        key;
    logic [1:0]          cls;
    logic                last;
    logic [5:0]          sig_t;
    logic [5:0]          ros_t;
    logic [5:0]          roo_t;
  } acct_beat_t;

  typedef struct {
    cmd_e                cmd;
    logic [255:0]        key;
    logic                s;
    logic                w;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [4:0]          idx;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [IN_TDATA_W-1:0] s_data = '0;
  logic [1:0] s_user = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [STATUS_W-1:0] m_user;
  logic m_last;

  signer_account_table_builder uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the account table.
  logic [255:0] tbl_key [MAX_ENTRIES];
  logic         tbl_sig [MAX_ENTRIES];
  logic         tbl_wr  [MAX_ENTRIES];
  int           tbl_count = 0;
  logic         tbl_built = 1'b0;
  acct_beat_t   pending_q [$];
  int errors = 0, n_items = 0, n_beats = 0, n_builds = 0, n_rejects = 0;
  int burst_left = 0;
  logic [255:0] key_pool [48];

  function automatic logic [1:0] order_class(logic s, logic w);
    return s ? (w ? 2'd0 : 2'd1) : (w ? 2'd2 : 2'd3);
  endfunction

  function automatic int find_entry(logic [255:0] k);
    for (int i = 0; i < tbl_count; i++) if (tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic acct_beat_t one_beat(logic [STATUS_W-1:0] st, int idx);
    acct_beat_t b;
    b = '0;
    b.status = st;
    b.idx = idx[4:0];
    b.last = 1'b1;
    return b;
  endfunction

  task automatic predict_table(cmd_e cmd, logic [255:0] k, logic s, logic w);
    int f, pos;
    int order [MAX_ENTRIES];
    logic [255:0] nk [MAX_ENTRIES];
    logic ns [MAX_ENTRIES];
    logic nw [MAX_ENTRIES];
    acct_beat_t b;
    logic [5:0] sig_t, ros_t, roo_t;
    f = find_entry(k);
    pos = 0;
    sig_t = '0; ros_t = '0; roo_t = '0;
    case (cmd)
      CMD_ADD: begin
        if (tbl_built) begin
          pending_q.push_back(one_beat(ST_REJECTED, 0));
        end else if (f >= 0) begin
          if (s) tbl_sig[f] = 1'b1;
          if (w) tbl_wr[f] = 1'b1;
          pending_q.push_back(one_beat(ST_OK, f));
        end else if (tbl_count >= MAX_ENTRIES) begin
          pending_q.push_back(one_beat(ST_REJECTED, 0));
        end else begin
          tbl_key[tbl_count] = k;
          tbl_sig[tbl_count] = s;
          tbl_wr[tbl_count] = w;
          pending_q.push_back(one_beat(ST_OK, tbl_count));
          tbl_count++;
        end
      end
      CMD_LOOKUP: begin
        pending_q.push_back(f >= 0 ? one_beat(ST_OK, f) : one_beat(ST_NOT_FOUND, 0));
      end
      CMD_CLEAR: begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          tbl_sig[i] = 1'b0;
          tbl_wr[i] = 1'b0;
        end
        tbl_count = 0;
        tbl_built = 1'b0;
        pending_q.push_back(one_beat(ST_OK, 0));
      end
      default: begin
        if (tbl_built) begin
          pending_q.push_back(one_beat(ST_BUILT, 0));
        end else if (tbl_count == 0) begin
          tbl_built = 1'b1;
          pending_q.push_back(one_beat(ST_EMPTY, 0));
        end else begin
          for (int c = 0; c < 4; c++)
            for (int i = 0; i < tbl_count; i++)
              if (order_class(tbl_sig[i], tbl_wr[i]) == c) order[pos++] = i;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_sig[i]) begin
              sig_t++;
              if (!tbl_wr[i]) ros_t++;
            end else if (!tbl_wr[i]) begin
              roo_t++;
            end
          end
          for (int i = 0; i < tbl_count; i++) begin
            b = '0;
            b.status = ST_OK;
            b.idx = i[4:0];
            b.prior = order[i][4:0];
            b.key = tbl_key[order[i]];
            b.cls = order_class(tbl_sig[order[i]], tbl_wr[order[i]]);
            b.last = (i + 1 == tbl_count);
            b.sig_t = sig_t;
            b.ros_t = ros_t;
            b.roo_t = roo_t;
            pending_q.push_back(b);
            nk[i] = tbl_key[order[i]];
            ns[i] = tbl_sig[order[i]];
            nw[i] = tbl_wr[order[i]];
          end
          for (int i = 0; i < tbl_count; i++) begin
            tbl_key[i] = nk[i];
            tbl_sig[i] = ns[i];
            tbl_wr[i] = nw[i];
          end
          tbl_built = 1'b1;
        end
      end
    endcase
  endtask

  task automatic send_cmd(cmd_row_t r);
    acct_beat_t b;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user <= r.cmd;
    s_data <= {6'b0, r.w, r.s, r.key};
    #1;
    while (!s_ready) begin
      @(negedge clk);
      #1;
    end
    if (r.cmd == CMD_BUILD) n_builds++;
    if (r.typed) begin
      predict_table(r.cmd, r.key, r.s, r.w);
      b = pending_q.pop_back();
      pending_q.push_back(one_beat(r.st, r.idx));
    end else begin
      predict_table(r.cmd, r.key, r.s, r.w);
    end
    n_items++;
    @(negedge clk);
  endtask

  task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
    errors++;
    $display("MISMATCH beat %0d %s: got %0h expected %0h", n_beats, what, got, want);
  endtask

  // Receiver: long ready stretches mix at random with random stall patterns.
  int stall_mode = 0, mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(10, 60);
      m_ready <= 1'b1;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        0: m_ready <= 1'b1;
        1: m_ready <= ($urandom_range(0, 3) != 0);
        default: m_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Each accepted result beat is sampled and checked at its rising edge.
  always @(posedge clk) begin
    acct_beat_t e;
    acct_beat_t got_beat;
    if (rst_n && m_valid && m_ready) begin
      n_beats++;
      got_beat = '0;
      got_beat.status = m_user;
      got_beat.idx = m_data[4:0];
      got_beat.prior = m_data[9:5];
      got_beat.key = m_data[265:10];
      got_beat.cls = m_data[267:266];
      got_beat.last = m_last;
      got_beat.sig_t = m_data[273:268];
      got_beat.ros_t = m_data[279:274];
      got_beat.roo_t = m_data[285:280];
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", '0, '0);
      end else begin
        e = pending_q.pop_front();
        if (got_beat.status != e.status) report_mismatch("status", got_beat.status, e.status);
        if (got_beat.idx != e.idx) report_mismatch("entry_index", got_beat.idx, e.idx);
        if (got_beat.prior != e.prior) report_mismatch("prior_index", got_beat.prior, e.prior);
        if (got_beat.key != e.key) report_mismatch("key", got_beat.key, e.key);
        if (got_beat.cls != e.cls) report_mismatch("order_class", got_beat.cls, e.cls);
        if (got_beat.last != e.last) report_mismatch("last", got_beat.last, e.last);
        if (got_beat.sig_t != e.sig_t) report_mismatch("signer_total", got_beat.sig_t, e.sig_t);
        if (got_beat.ros_t != e.ros_t) report_mismatch("ro_signer_total", got_beat.ros_t, e.ros_t);
        if (got_beat.roo_t != e.roo_t) report_mismatch("ro_other_total", got_beat.roo_t, e.roo_t);
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("timeout with %0d beats pending", pending_q.size());
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [255:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic cmd_row_t mk(cmd_e c, logic [255:0] k, logic s, logic w);
    cmd_row_t r;
    r.cmd = c; r.key = k; r.s = s; r.w = w;
    r.typed = 1'b0; r.st = '0; r.idx = '0;
    return r;
  endfunction

  function automatic cmd_row_t mkt(cmd_e c, logic [255:0] k, logic s, logic w,
                                   logic [STATUS_W-1:0] st, logic [4:0] idx);
    cmd_row_t r;
    r = mk(c, k, s, w);
    r.typed = 1'b1; r.st = st; r.idx = idx;
    return r;
  endfunction

  cmd_row_t directed [$];
  initial begin
    cmd_row_t r;
    int pick;
    logic [255:0] ka, kb;
    for (int i = 0; i < 48; i++) key_pool[i] = rand_key();
    ka = {64'h0123456789abcdef, 64'hfedcba9876543210, 64'h8000000000000001, 64'h5a5a5a5a5a5a5a5a};
    kb = {4{64'h7fffffffffffffff}};
    directed = '{
      mkt(CMD_BUILD, '0, 0, 0, ST_EMPTY, 0),
      mkt(CMD_BUILD, '0, 0, 0, ST_BUILT, 0),
      mkt(CMD_ADD, ka, 1, 1, ST_REJECTED, 0),
      mkt(CMD_CLEAR, '0, 0, 0, ST_OK, 0),
      mkt(CMD_LOOKUP, ka, 0, 0, ST_NOT_FOUND, 0),
      mkt(CMD_ADD, '0, 0, 0, ST_OK, 0),
      mkt(CMD_ADD, '1, 1, 1, ST_OK, 1),
      mkt(CMD_ADD, ka, 1, 0, ST_OK, 2),
      mkt(CMD_ADD, kb, 0, 1, ST_OK, 3),
      mkt(CMD_ADD, '0, 0, 0, ST_OK, 0),
      mkt(CMD_ADD, kb, 1, 0, ST_OK, 3),
      mk(CMD_ADD, ~ka, 0, 0),
      mkt(CMD_LOOKUP, '1, 0, 0, ST_OK, 1),
      mk(CMD_BUILD, '0, 1, 1),
      mkt(CMD_ADD, ~kb, 1, 1, ST_REJECTED, 0),
      mk(CMD_LOOKUP, '0, 0, 0),
      mk(CMD_LOOKUP, kb, 1, 1),
      mkt(CMD_BUILD, '0, 0, 0, ST_BUILT, 0),
      mkt(CMD_CLEAR, '1, 1, 1, ST_OK, 0),
      mkt(CMD_LOOKUP, '1, 0, 0, ST_NOT_FOUND, 0)
    };
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tbl_key[i] = '0; tbl_sig[i] = 1'b0; tbl_wr[i] = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_cmd(directed[i]);

    // One pass that fills the table past its capacity.
    for (int i = 0; i <= MAX_ENTRIES; i++)
      send_cmd(mk(CMD_ADD, key_pool[i], $urandom_range(0, 1), $urandom_range(0, 1)));
    send_cmd(mk(CMD_LOOKUP, key_pool[MAX_ENTRIES - 1], 0, 0));
    send_cmd(mk(CMD_BUILD, '0, 0, 0));
    send_cmd(mk(CMD_CLEAR, '0, 0, 0));

    // Mostly add sequences over a key pool closed by a build, plus noise.
    while (n_items < 140) begin
      repeat ($urandom_range(1, 10)) begin
        pick = $urandom_range(0, 15);
        r = mk(CMD_ADD, key_pool[pick], $urandom_range(0, 1), $urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) r.cmd = CMD_LOOKUP;
        if ($urandom_range(0, 9) == 0) r.key = rand_key();
        send_cmd(r);
      end
      send_cmd(mk(CMD_BUILD, rand_key(), $urandom_range(0, 1), $urandom_range(0, 1)));
      repeat ($urandom_range(0, 3))
        send_cmd(mk(cmd_e'($urandom_range(0, 2)), key_pool[$urandom_range(0, 15)],
                    $urandom_range(0, 1), $urandom_range(0, 1)));
      send_cmd(mk(CMD_CLEAR, rand_key(), $urandom_range(0, 1), $urandom_range(0, 1)));
    end
    s_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Sent %0d commands including %0d builds; checked %0d result beats.",
             n_items, n_builds, n_beats);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
